### src/ir_pulse_width_receiver_assert.svh
// Assertion macros for the IR pulse-width receiver checkers.
// Self-contained; used by files that take it in by include.
`ifndef IR_PULSE_WIDTH_RECEIVER_ASSERT_SVH
`define IR_PULSE_WIDTH_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IRPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("irpw assertion failed");

// next-cycle implication, checked outside reset
`define IRPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("irpw assertion failed");

`endif

### src/irpw_pkg.sv
// Shared types and constants of the IR pulse-width receiver.
// No dependencies; imported by the core, the top level and the checker.
package irpw_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  // payload length must fit the block and let the 6-bit index reach length+1
  localparam int unsigned LenCap = (BLOCK_BYTES < 61) ? BLOCK_BYTES : 61;
  localparam logic [7:0]  LEN_MAX = 8'(LenCap);

  localparam logic [15:0] MIN_PULSE_RST        = 16'd156;
  localparam logic [15:0] HDR_MARK_MIN_RST     = 16'd21270;
  localparam logic [15:0] HDR_MARK_MAX_RST     = 16'd28777;
  localparam logic [15:0] HDR_SPACE_MIN_RST    = 16'd10635;
  localparam logic [15:0] HDR_SPACE_MAX_RST    = 16'd14388;
  localparam logic [15:0] ONE_THRESHOLD_RST    = 16'd3128;

  typedef enum logic [2:0] {
    CFG_MIN_PULSE     = 3'd0,
    CFG_HDR_MARK_MIN  = 3'd1,
    CFG_HDR_MARK_MAX  = 3'd2,
    CFG_HDR_SPACE_MIN = 3'd3,
    CFG_HDR_SPACE_MAX = 3'd4,
    CFG_ONE_THRESHOLD = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HDR_MARK   = 2'd0,
    PH_HDR_SPACE  = 2'd1,
    PH_DATA_MARK  = 2'd2,
    PH_DATA_SPACE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RESYNC = 3'd1,
    ST_RANGE  = 3'd2,
    ST_HEADER = 3'd3,
    ST_SIZE   = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] hdr_mark_min;
    logic [15:0] hdr_mark_max;
    logic [15:0] hdr_space_min;
    logic [15:0] hdr_space_max;
    logic [15:0] one_threshold;
  } cfg_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [5:0] byte_index;
    logic       frame_done;
    status_e    status;
  } res_t;

endpackage

### src/irpw_core.sv
// Frame decoder of the IR pulse-width receiver: interval measurement,
// header windows, bit packing and frame bookkeeping. Uses irpw_pkg.
module irpw_core import irpw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] edge_time_i,
  input  cfg_t        cfg_i,
  output res_t        res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] last_q, last_d;
  logic        have_q, have_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [5:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  plen_q, plen_d;

  logic        resync;
  logic [31:0] diff;
  logic        out_of_range;
  logic        hdr_mark_ok;
  logic        hdr_space_ok;
  logic        bit_val;
  logic        byte_full;
  logic [7:0]  new_shift;
  logic        bad_blocks;
  logic        bad_len;
  logic        last_byte;

  assign resync       = !have_q || (last_q > edge_time_i);
  assign diff         = edge_time_i - last_q;
  assign out_of_range = (diff > {16'b0, cfg_i.hdr_mark_max}) ||
                        (diff < {16'b0, cfg_i.min_pulse});
  // upper bound of the mark window is already enforced by the range check
  assign hdr_mark_ok  = diff >= {16'b0, cfg_i.hdr_mark_min};
  assign hdr_space_ok = (diff >= {16'b0, cfg_i.hdr_space_min}) &&
                        (diff <= {16'b0, cfg_i.hdr_space_max});
  assign bit_val      = diff > {16'b0, cfg_i.one_threshold};
  assign byte_full    = bit_cnt_q == 3'd7;
  assign new_shift    = {shift_q[6:0], bit_val};
  assign bad_blocks   = (byte_cnt_q == 6'd0) && (new_shift != 8'd1);
  assign bad_len      = (byte_cnt_q == 6'd1) &&
                        ((new_shift == 8'd0) || (new_shift > LEN_MAX));
  assign last_byte    = (byte_cnt_q > 6'd1) &&
                        ({3'b0, byte_cnt_q} >= ({1'b0, plen_q} + 9'd1));

  // next state
  always_comb begin
    logic clear;
    clear      = 1'b0;
    phase_d    = phase_q;
    last_d     = edge_time_i;
    have_d     = 1'b1;
    shift_d    = shift_q;
    bit_cnt_d  = bit_cnt_q;
    byte_cnt_d = byte_cnt_q;
    plen_d     = plen_q;
    if (resync || out_of_range) begin
      clear = 1'b1;
    end else begin
      case (phase_q)
        PH_HDR_MARK: begin
          if (hdr_mark_ok) phase_d = PH_HDR_SPACE;
          else clear = 1'b1;
        end
        PH_HDR_SPACE: begin
          if (hdr_space_ok) phase_d = PH_DATA_MARK;
          else clear = 1'b1;
        end
        PH_DATA_MARK: begin
          phase_d = PH_DATA_SPACE;
          if (byte_full) begin
            shift_d    = 8'd0;
            bit_cnt_d  = 3'd0;
            byte_cnt_d = byte_cnt_q + 6'd1;
            if (byte_cnt_q == 6'd1) plen_d = new_shift;
            if (bad_blocks || bad_len || last_byte) clear = 1'b1;
          end else begin
            shift_d   = new_shift;
            bit_cnt_d = bit_cnt_q + 3'd1;
          end
        end
        PH_DATA_SPACE: phase_d = PH_DATA_MARK;
        default:       clear = 1'b1;
      endcase
    end
    if (clear) begin
      phase_d    = PH_HDR_MARK;
      shift_d    = 8'd0;
      bit_cnt_d  = 3'd0;
      byte_cnt_d = 6'd0;
      plen_d     = 8'd0;
    end
  end

  // result of this edge
  always_comb begin
    res_o = '0;
    res_o.status = ST_OK;
    if (resync) begin
      res_o.status = ST_RESYNC;
    end else if (out_of_range) begin
      res_o.status = ST_RANGE;
    end else begin
      case (phase_q)
        PH_HDR_MARK:  if (!hdr_mark_ok) res_o.status = ST_HEADER;
        PH_HDR_SPACE: if (!hdr_space_ok) res_o.status = ST_HEADER;
        PH_DATA_MARK: begin
          if (byte_full) begin
            res_o.byte_valid = 1'b1;
            res_o.byte_value = new_shift;
            res_o.byte_index = byte_cnt_q;
            res_o.frame_done = last_byte;
            if (bad_blocks || bad_len) res_o.status = ST_SIZE;
          end
        end
        default: res_o.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR_MARK;
      last_q     <= 32'd0;
      have_q     <= 1'b0;
      shift_q    <= 8'd0;
      bit_cnt_q  <= 3'd0;
      byte_cnt_q <= 6'd0;
      plen_q     <= 8'd0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      last_q     <= last_d;
      have_q     <= have_d;
      shift_q    <= shift_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      plen_q     <= plen_d;
    end
  end

endmodule

### src/ir_pulse_width_receiver.sv
// IR pulse-width receiver: configuration registers, input and result
// registers around irpw_core. Uses irpw_pkg.
//
// Usage: each input request carries the microsecond timestamp of one
// receiver pin edge (edge_time_us_i, valid/ready). Every request gives
// exactly one result request on the output channel: byte_valid_o with
// byte_value_o/byte_index_o when the edge completed a byte, frame_done_o
// on the last byte of a frame, and status_o (ok, resync, range, header,
// size). An accepted edge is held in the input register, decoded in a single
// pass and its result held in the result register; throughput is one edge
// per cycle unless the output stalls. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), to be written only while no request
// is in flight, which the block does not enforce; unknown indexes are ignored.
// Reset loads the default windows, clears the frame and forgets the last
// edge, so the first edge after reset reports a resync. When the receiver
// holds out_ready_i low the result register holds, the input register
// fills, and in_ready_o then drops until the result is taken.
module ir_pulse_width_receiver import irpw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] edge_time_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        byte_valid_o,
  output logic [7:0]  byte_value_o,
  output logic [5:0]  byte_index_o,
  output logic        frame_done_o,
  output logic [2:0]  status_o
);

  cfg_t        cfg_q;
  logic        in_vld_q;
  logic [31:0] edge_q;
  logic        out_vld_q;
  res_t        res_q;
  res_t        res_d;
  logic        s2_free;
  logic        adv;

  assign s2_free    = !out_vld_q || out_ready_i;
  assign adv        = in_vld_q && s2_free;
  assign in_ready_o = !in_vld_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse     <= MIN_PULSE_RST;
      cfg_q.hdr_mark_min  <= HDR_MARK_MIN_RST;
      cfg_q.hdr_mark_max  <= HDR_MARK_MAX_RST;
      cfg_q.hdr_space_min <= HDR_SPACE_MIN_RST;
      cfg_q.hdr_space_max <= HDR_SPACE_MAX_RST;
      cfg_q.one_threshold <= ONE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_PULSE:     cfg_q.min_pulse     <= cfg_data_i;
        CFG_HDR_MARK_MIN:  cfg_q.hdr_mark_min  <= cfg_data_i;
        CFG_HDR_MARK_MAX:  cfg_q.hdr_mark_max  <= cfg_data_i;
        CFG_HDR_SPACE_MIN: cfg_q.hdr_space_min <= cfg_data_i;
        CFG_HDR_SPACE_MAX: cfg_q.hdr_space_max <= cfg_data_i;
        CFG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) in_vld_q <= 1'b1;
      else if (adv)                 in_vld_q <= 1'b0;
      if (adv)              out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) edge_q <= edge_time_us_i;
    if (adv)                      res_q  <= res_d;
  end

  irpw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .edge_time_i (edge_q),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  assign out_valid_o  = out_vld_q;
  assign byte_valid_o = res_q.byte_valid;
  assign byte_value_o = res_q.byte_value;
  assign byte_index_o = res_q.byte_index;
  assign frame_done_o = res_q.frame_done;
  assign status_o     = res_q.status;

endmodule

### src/irpw_checker.sv
// Port-level checker of the IR pulse-width receiver and its bind.
// Uses irpw_pkg and ir_pulse_width_receiver_assert.svh.
`include "ir_pulse_width_receiver_assert.svh"

module irpw_checker import irpw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        byte_valid_o,
  input logic [7:0]  byte_value_o,
  input logic [5:0]  byte_index_o,
  input logic        frame_done_o,
  input logic [2:0]  status_o
);

  // stalled result holds
  `IRPW_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable({byte_valid_o, byte_value_o, byte_index_o, frame_done_o, status_o}))

  // no byte means empty byte fields
  `IRPW_ASSERT_IMP(a_empty, clk_i, rst_ni, out_valid_o && !byte_valid_o, byte_value_o == 8'd0 && byte_index_o == 6'd0 && !frame_done_o)

  // frame end only on a clean data byte after the two size bytes
  `IRPW_ASSERT_IMP(a_done, clk_i, rst_ni, out_valid_o && frame_done_o, byte_valid_o && status_o == ST_OK && byte_index_o > 6'd1)

  // timing and header errors never carry a byte
  `IRPW_ASSERT_IMP(a_err, clk_i, rst_ni, out_valid_o && (status_o == ST_RESYNC || status_o == ST_RANGE || status_o == ST_HEADER), !byte_valid_o)

endmodule

bind ir_pulse_width_receiver irpw_checker u_irpw_checker (.*);
